[rtl/core/kr_pkg.sv]
// shared types and constants for the key reconciliation chain
`default_nettype none

package kr_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned NCELL = 9;
  localparam int unsigned CW    = 19;
  localparam int unsigned VW    = 18;
  localparam int unsigned KW    = 2;
  localparam int unsigned BW    = LANES * KW;

  localparam logic [CW-1:0] MOD_Q     = CW'(260609);
  localparam logic [CW-1:0] TWO_Q     = CW'(521218);
  localparam logic [CW-1:0] TWO_Q_M1  = CW'(521217);

  localparam logic [CW-1:0] CUTOFF [NCELL] = '{
    CW'(0), CW'(65153), CW'(130305), CW'(195457), CW'(260609),
    CW'(325762), CW'(390914), CW'(456066), CW'(521218)
  };

  localparam logic [KW-1:0] KEY_MASK = 2'b11;

  typedef struct packed {
    logic [CW-1:0] w;
    logic [CW-1:0] d;
    logic [CW-1:0] v;
    logic          par;
    logic          hint;
  } lane_t;

endpackage

`default_nettype wire

[rtl/core/kr_cell.sv]
// one cutoff cell: compares each lane against its cutoff and keeps the nearest so far
`default_nettype none

module kr_cell import kr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [CW-1:0]       cut_i,
  input  logic                valid_i,
  input  lane_t [LANES-1:0]   lane_i,
  output logic                valid_o,
  output lane_t [LANES-1:0]   lane_o
);

  lane_t [LANES-1:0] lane_d;
  lane_t [LANES-1:0] lane_q;
  logic              valid_q;

  always_comb begin
    logic          le;
    logic          eq;
    logic [CW-1:0] d_c;
    logic [CW-1:0] v_c;
    le  = 1'b0;
    eq  = 1'b0;
    d_c = '0;
    v_c = '0;
    for (int l = 0; l < LANES; l++) begin
      lane_d[l] = lane_i[l];
      le = (cut_i <= lane_i[l].w);
      eq = (cut_i == lane_i[l].w);
      if (le) begin
        d_c = eq ? '0
                 : CW'({1'b0, lane_i[l].w} - {1'b0, cut_i} + (CW+1)'(1));
        // a candidate of minus one wraps to the top of the range
        v_c = (cut_i == '0) ? TWO_Q_M1 : cut_i - CW'(1);
      end else begin
        d_c = cut_i - lane_i[l].w;
        v_c = cut_i;
      end
      if (d_c < lane_i[l].d) begin
        lane_d[l].d = d_c;
        lane_d[l].v = v_c;
      end
      lane_d[l].par = lane_i[l].par ^ le;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

`default_nettype wire

[rtl/core/kr_out.sv]
// output stage: picks kept or moved value, reduces, rounds and packs the key word
`default_nettype none

module kr_out import kr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  lane_t [LANES-1:0] lane_i,
  output logic              valid_o,
  output logic [BW-1:0]     key_o
);

  logic [BW-1:0] key_d;
  logic [BW-1:0] key_q;
  logic          valid_q;

  always_comb begin
    logic [CW-1:0] x;
    logic [2:0]    k;
    x     = '0;
    k     = '0;
    key_d = '0;
    for (int l = 0; l < LANES; l++) begin
      // par holds the parity of the number of cutoffs at or below w, cutoff zero included
      x = (~lane_i[l].par == lane_i[l].hint) ? lane_i[l].w : lane_i[l].v;
      if (x >= TWO_Q) begin
        x = x - TWO_Q;
      end
      k = 3'(x >= CUTOFF[1]) + 3'(x >= CUTOFF[3])
        + 3'(x >= CUTOFF[5]) + 3'(x >= CUTOFF[7]);
      key_d[KW*(LANES-1-l) +: KW] = k[KW-1:0] & KEY_MASK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;

endmodule

`default_nettype wire

[rtl/core/kem_key_reconciliation.sv]
// top level of the key reconciliation block
`default_nettype none

// Takes one word of four coefficients with their hint bits per clock unless the
// output stalls, and returns one key byte per word, in order, after the word has
// passed the nine cell registers and the output register. Each coefficient is
// doubled and walks a chain of nine cells, one per cutoff point, each keeping the
// nearest cutoff seen so far; a final stage picks kept or moved value, reduces it
// and rounds it to two bits. The whole chain advances together, so a stall on the
// output holds every stage and the input stall follows it in the same cycle.

module kem_key_reconciliation import kr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [VW-1:0] coef_0_i,
  input  logic [VW-1:0] coef_1_i,
  input  logic [VW-1:0] coef_2_i,
  input  logic [VW-1:0] coef_3_i,
  input  logic          hint_0_i,
  input  logic          hint_1_i,
  input  logic          hint_2_i,
  input  logic          hint_3_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [BW-1:0] key_byte_o
);

  lane_t [LANES-1:0] chain [NCELL+1];
  logic [NCELL:0]    vld;
  logic [VW-1:0]     coef [LANES];
  logic [LANES-1:0]  hint;
  logic              en;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign coef[0] = coef_0_i;
  assign coef[1] = coef_1_i;
  assign coef[2] = coef_2_i;
  assign coef[3] = coef_3_i;
  assign hint    = {hint_3_i, hint_2_i, hint_1_i, hint_0_i};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      chain[0][l].w    = {coef[l], 1'b0};
      chain[0][l].d    = MOD_Q;
      chain[0][l].v    = '0;
      chain[0][l].par  = 1'b0;
      chain[0][l].hint = hint[l];
    end
  end

  assign vld[0] = in_valid_i;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    kr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .cut_i   (CUTOFF[g]),
      .valid_i (vld[g]),
      .lane_i  (chain[g]),
      .valid_o (vld[g+1]),
      .lane_o  (chain[g+1])
    );
  end

  kr_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld[NCELL]),
    .lane_i  (chain[NCELL]),
    .valid_o (out_valid_o),
    .key_o   (key_byte_o)
  );

  a_stall_only_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output word");

  a_last_cell_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && vld[NCELL]) |=> out_valid_o)
    else $error("word from last cell lost");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !vld[NCELL]) |=> !out_valid_o)
    else $error("output word repeated");

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the key reconciliation block
`timescale 1ns / 1ps

module testbench;
  import kr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 600;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int NPHASE = 3;
  localparam int TX_IDLE [NPHASE] = '{32, 59, 0};
  localparam int RX_IDLE [NPHASE] = '{59, 32, 0};
  localparam int VMAX = (1 << VW) - 1;

  typedef struct packed {
    logic [LANES-1:0][VW-1:0] coef;
    logic [LANES-1:0]         hint;
  } coef_word_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [VW-1:0] coef_0_i = '0;
  logic [VW-1:0] coef_1_i = '0;
  logic [VW-1:0] coef_2_i = '0;
  logic [VW-1:0] coef_3_i = '0;
  logic          hint_0_i = 1'b0;
  logic          hint_1_i = 1'b0;
  logic          hint_2_i = 1'b0;
  logic          hint_3_i = 1'b0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [BW-1:0] key_byte_o;

  coef_word_t    pending_words [$];
  logic [BW-1:0] expected_keys [$];
  coef_word_t    offered_word = '0;
  logic [BW-1:0] wanted_key;
  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  int            idle_phase = 0;
  int            words_in = 0;
  int            hold_mark = 0;
  int            hold_left = 0;
  logic          held_once = 1'b0;
  int            cycle_cnt = 0;
  int            err_cnt = 0;

  kem_key_reconciliation uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .coef_0_i    (coef_0_i),
    .coef_1_i    (coef_1_i),
    .coef_2_i    (coef_2_i),
    .coef_3_i    (coef_3_i),
    .hint_0_i    (hint_0_i),
    .hint_1_i    (hint_1_i),
    .hint_2_i    (hint_2_i),
    .hint_3_i    (hint_3_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_byte_o  (key_byte_o)
  );

  function automatic logic [KW-1:0] reconcile_coef(logic [VW-1:0] coef, logic hint);
    int q, w, x, best_d, best_v, c, d, v, i;
    q = int'(MOD_Q);
    w = int'(coef) * 2;
    if ((((4 * w) / q) % 2) == int'(hint)) begin
      x = w;
    end else begin
      best_d = q;
      best_v = 0;
      for (i = 0; i < NCELL; i++) begin
        c = int'(CUTOFF[i]);
        if (c < w) begin
          d = w - c + 1;
          v = c - 1;
        end else if (c == w) begin
          d = 0;
          v = c - 1;
        end else begin
          d = c - w;
          v = c;
        end
        if (d < best_d) begin
          best_d = d;
          best_v = v;
        end
      end
      x = best_v;
    end
    if (x < 0) x += 2 * q;
    if (x >= 2 * q) x -= 2 * q;
    return KW'((2 * x + q / 2) / q) & KEY_MASK;
  endfunction

  function automatic logic [BW-1:0] predict_key_byte(coef_word_t wd);
    logic [BW-1:0] k;
    int i;
    k = '0;
    for (i = 0; i < LANES; i++) begin
      k[BW-1-KW*i -: KW] = reconcile_coef(wd.coef[i], wd.hint[i]);
    end
    return k;
  endfunction

  function automatic coef_word_t make_word(int c0, int c1, int c2, int c3, logic [3:0] h);
    coef_word_t wd;
    wd.coef[0] = VW'(c0);
    wd.coef[1] = VW'(c1);
    wd.coef[2] = VW'(c2);
    wd.coef[3] = VW'(c3);
    wd.hint = h;
    return wd;
  endfunction

  // mostly reduced coefficients, some near cutoffs or parity edges, some full width
  function automatic coef_word_t random_word();
    coef_word_t wd;
    int i, pick, base;
    for (i = 0; i < LANES; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        base = $urandom_range(int'(MOD_Q) - 1);
      end else if (pick < 75) begin
        base = int'(CUTOFF[$urandom_range(NCELL - 1)]) / 2 + $urandom_range(6) - 3;
      end else if (pick < 88) begin
        base = ($urandom_range(8) * int'(MOD_Q)) / 8 + $urandom_range(6) - 3;
      end else begin
        base = $urandom_range(VMAX);
      end
      if (base < 0) base = 0;
      if (base > VMAX) base = VMAX;
      wd.coef[i] = VW'(base);
    end
    wd.hint = 4'($urandom_range(15));
    return wd;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    err_cnt++;
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_keys.push_back(predict_key_byte(offered_word));
        words_in <= words_in + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered_word <= pending_words[0];
          coef_0_i <= pending_words[0].coef[0];
          coef_1_i <= pending_words[0].coef[1];
          coef_2_i <= pending_words[0].coef[2];
          coef_3_i <= pending_words[0].coef[3];
          hint_0_i <= pending_words[0].hint[0];
          hint_1_i <= pending_words[0].hint[1];
          hint_2_i <= pending_words[0].hint[2];
          hint_3_i <= pending_words[0].hint[3];
          void'(pending_words.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off in the last phase
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held_once && idle_phase == NPHASE - 1 && words_in >= hold_mark) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES;
      held_once <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_keys.size() == 0) begin
        report_mismatch($sformatf("key byte %02h with nothing outstanding", key_byte_o));
      end else begin
        wanted_key = expected_keys.pop_front();
        if (key_byte_o !== wanted_key) begin
          report_mismatch($sformatf("key_byte got %02h want %02h", key_byte_o, wanted_key));
        end
      end
    end
  end

  initial begin
    int ph, n;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    for (ph = 0; ph < NPHASE; ph++) begin
      @(negedge clk_i);
      tx_idle_pct = TX_IDLE[ph];
      rx_idle_pct = RX_IDLE[ph];
      idle_phase = ph;
      hold_mark = words_in + 100;
      if (ph == 0) begin
        // zero word, negative candidate, top of range and wrap above 2q
        pending_words.push_back(make_word(0, 0, 0, 0, 4'b0000));
        pending_words.push_back(make_word(0, 0, 0, 0, 4'b1111));
        pending_words.push_back(make_word(260608, 260608, 260608, 260608, 4'b0101));
        pending_words.push_back(make_word(260608, 260608, 260608, 260608, 4'b1010));
        pending_words.push_back(make_word(VMAX, VMAX, VMAX, VMAX, 4'b0000));
        pending_words.push_back(make_word(VMAX, VMAX, VMAX, VMAX, 4'b1111));
        pending_words.push_back(make_word(260609, 261000, 262000, 260610, 4'b0011));
        pending_words.push_back(make_word(260609, 261000, 262000, 260610, 4'b1100));
        // doubled value sitting exactly on a cutoff, then one below a cutoff
        pending_words.push_back(make_word(162881, 195457, 228033, 260609, 4'b0000));
        pending_words.push_back(make_word(162881, 195457, 228033, 260609, 4'b1111));
        pending_words.push_back(make_word(65152, 97728, 130304, 32576, 4'b0110));
        pending_words.push_back(make_word(65152, 97728, 130304, 32576, 4'b1001));
        // parity edges
        pending_words.push_back(make_word(32576, 32577, 65152, 65153, 4'b0000));
        pending_words.push_back(make_word(32576, 32577, 65152, 65153, 4'b1111));
        pending_words.push_back(make_word(97728, 97729, 130304, 130305, 4'b0101));
        pending_words.push_back(make_word(97728, 97729, 130304, 130305, 4'b1010));
        // tie between two cutoffs, the lower one wins
        pending_words.push_back(make_word(16288, 16288, 16289, 16287, 4'b1111));
        pending_words.push_back(make_word(16288, 16288, 16289, 16287, 4'b0000));
        pending_words.push_back(make_word(131071, 87381, 174762, 43690, 4'b1011));
        pending_words.push_back(make_word(131072, 174762, 87381, 218452, 4'b0100));
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) pending_words.push_back(random_word());
      while (pending_words.size() != 0 || in_valid_i) @(posedge clk_i);
      if (ph == 0) begin
        while (expected_keys.size() != 0) @(posedge clk_i);
      end
    end
    while (expected_keys.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_keys.size() != 0) begin
      report_mismatch($sformatf("%0d key bytes never arrived", expected_keys.size()));
    end
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/kr_pkg.sv
rtl/core/kr_cell.sv
rtl/core/kr_out.sv
rtl/core/kem_key_reconciliation.sv
tb/testbench.sv
